[src/sfb_pkg.sv]
// Shared types and constants of the sprite frame store with blit and collision.
`default_nettype none

package sfb_pkg;

  // Fixed widths of the sprite and of one packed page column.
  localparam int SPRITE_BITS = 16;
  localparam int PAGE_HEIGHT = 8;

  // Ground level after reset: no row is at or below it, so every row can collide.
  localparam logic [5:0] GROUND_RESET = 6'd32;

  // Command codes of an input item.
  typedef enum logic [1:0] {
    CMD_DRAW      = 2'd0,
    CMD_SPAN      = 2'd1,
    CMD_CLEAR_ALL = 2'd2,
    CMD_READ      = 2'd3
  } cmd_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_MODIFY,
    S_PAGE,
    S_DONE
  } state_t;

  // One input item.
  typedef struct packed {
    cmd_t        cmd;
    logic [4:0]  pixel_row;
    logic [6:0]  pixel_col;
    logic [15:0] row_bits;
    logic [4:0]  span_width;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic       collision;
    logic [7:0] packed_byte;
  } out_item_t;

  // Request to the span unit: which pixels to set or clear in one row.
  typedef struct packed {
    logic        clear;
    logic [15:0] bits;
    logic [4:0]  span;
    logic [6:0]  col;
  } span_req_t;

endpackage

`default_nettype wire

[src/sprite_framebuffer_blit_collide_top.sv]
// Draw and clear span pass through the read and modify states before the result is loaded,
// a read first walks the eight rows of a page, and clear all and a read off the edge go straight on.
// One item at a time; the next transfer is taken in the cycle after the result is loaded,
// and is held off while the output register is full.
// Reset clears the per-row valid bits, so the store reads as zero with no clearing pass,
// and sets the ground level to 32.
`default_nettype none

module sprite_framebuffer_blit_collide_top #(
  parameter int ROWS             = 32,
  parameter int COLUMNS          = 128,
  parameter int MAX_SPRITE_WIDTH = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire sfb_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output sfb_pkg::out_item_t      out_data,
  input  wire logic               cfg_we,
  input  wire logic [5:0]         cfg_wdata
);

  localparam int AW = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int CW = $clog2(COLUMNS);

  sfb_pkg::state_t   state, state_next;
  sfb_pkg::in_item_t item_q;
  logic [5:0]        ground;
  logic [ROWS-1:0]   valid;
  logic [3:0]        cnt;
  logic              pend_ok;
  logic [7:0]        packed_q;
  logic              hit_q;

  logic               accept;
  logic               load_out;
  logic               in_row_ok;
  logic               in_col_ok;
  logic               row_ok;
  logic [AW-1:0]      row_idx;
  logic [CW-1:0]      col_idx;
  logic [4:0]         page_row;
  logic               page_ok;
  logic [AW-1:0]      page_idx;
  logic               ram_we;
  logic [AW-1:0]      ram_raddr;
  logic [COLUMNS-1:0] ram_rdata;
  logic [COLUMNS-1:0] old_row;
  logic [COLUMNS-1:0] new_row;
  logic               check_en;
  logic               span_hit;
  sfb_pkg::span_req_t span_req;

  // Address decode of the incoming and the held item.
  assign in_row_ok = int'(in_data.pixel_row) < ROWS;
  assign in_col_ok = int'(in_data.pixel_col) < COLUMNS;
  assign row_ok    = int'(item_q.pixel_row) < ROWS;
  assign row_idx   = AW'(item_q.pixel_row);
  assign col_idx   = CW'(item_q.pixel_col);
  assign page_row  = {item_q.pixel_row[4:3], cnt[2:0]};
  assign page_ok   = (int'(page_row) < ROWS) && !cnt[3];
  assign page_idx  = AW'(page_row);

  // Next-state logic of the sequencer.
  always_comb begin
    state_next = state;
    case (state)
      sfb_pkg::S_IDLE: begin
        if (in_valid) begin
          case (in_data.cmd)
            sfb_pkg::CMD_DRAW, sfb_pkg::CMD_SPAN: begin
              state_next = in_row_ok ? sfb_pkg::S_READ : sfb_pkg::S_DONE;
            end
            sfb_pkg::CMD_READ: begin
              state_next = in_col_ok ? sfb_pkg::S_PAGE : sfb_pkg::S_DONE;
            end
            default: begin
              state_next = sfb_pkg::S_DONE;
            end
          endcase
        end
      end
      sfb_pkg::S_READ: begin
        state_next = sfb_pkg::S_MODIFY;
      end
      sfb_pkg::S_MODIFY: begin
        state_next = sfb_pkg::S_DONE;
      end
      sfb_pkg::S_PAGE: begin
        if (cnt == 4'(sfb_pkg::PAGE_HEIGHT)) begin
          state_next = sfb_pkg::S_DONE;
        end
      end
      sfb_pkg::S_DONE: begin
        if (!out_valid || out_ready) begin
          state_next = sfb_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = sfb_pkg::S_IDLE;
      end
    endcase
  end

  // Output decode of the sequencer.
  always_comb begin
    in_ready  = (state == sfb_pkg::S_IDLE);
    accept    = in_valid && (state == sfb_pkg::S_IDLE);
    load_out  = (state == sfb_pkg::S_DONE) && (!out_valid || out_ready);
    ram_we    = (state == sfb_pkg::S_MODIFY);
    ram_raddr = (state == sfb_pkg::S_PAGE) ? page_idx : row_idx;
    check_en  = (state == sfb_pkg::S_MODIFY) && row_ok &&
                ({1'b0, item_q.pixel_row} < ground);
  end

  // Rows never written since the last clear read as zero.
  assign old_row = valid[row_idx] ? ram_rdata : '0;

  assign span_req.clear = (item_q.cmd == sfb_pkg::CMD_SPAN);
  assign span_req.bits  = item_q.row_bits;
  assign span_req.span  = item_q.span_width;
  assign span_req.col   = item_q.pixel_col;

  sfb_span_unit #(
    .COLUMNS          (COLUMNS),
    .MAX_SPRITE_WIDTH (MAX_SPRITE_WIDTH)
  ) u_span (
    .req      (span_req),
    .old_row  (old_row),
    .check_en (check_en),
    .new_row  (new_row),
    .hit      (span_hit)
  );

  sfb_ram #(
    .WIDTH (COLUMNS),
    .DEPTH (ROWS)
  ) u_rows (
    .clk   (clk),
    .we    (ram_we),
    .waddr (row_idx),
    .wdata (new_row),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Control state: sequencer, row valid bits, ground level, result flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= sfb_pkg::S_IDLE;
      valid     <= '0;
      ground    <= sfb_pkg::GROUND_RESET;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        ground <= cfg_wdata;
      end
      if (accept && (in_data.cmd == sfb_pkg::CMD_CLEAR_ALL)) begin
        valid <= '0;
      end else if (ram_we) begin
        // A collision empties the store before the row is written.
        if (span_hit) begin
          valid <= ROWS'(1) << row_idx;
        end else begin
          valid[row_idx] <= 1'b1;
        end
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Item holding, page gathering and result registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      item_q   <= in_data;
      hit_q    <= 1'b0;
      packed_q <= '0;
      cnt      <= '0;
      pend_ok  <= 1'b0;
    end else begin
      if (ram_we) begin
        hit_q <= span_hit;
      end
      if (state == sfb_pkg::S_PAGE) begin
        // Issue row cnt while the row issued in the previous cycle comes back.
        cnt     <= cnt + 4'd1;
        pend_ok <= page_ok && valid[page_idx];
        if (cnt != 4'd0) begin
          packed_q <= {pend_ok & ram_rdata[col_idx], packed_q[7:1]};
        end
      end
    end
    if (load_out) begin
      out_data.collision   <= hit_q;
      out_data.packed_byte <= packed_q;
    end
  end

  // A page walk only ever serves a read command.
  assert property (@(posedge clk) disable iff (rst)
    (state == sfb_pkg::S_PAGE) |-> (item_q.cmd == sfb_pkg::CMD_READ))
    else $error("page walk running for a command other than read");

  // Only a draw can report a collision.
  assert property (@(posedge clk) disable iff (rst)
    span_hit |-> (item_q.cmd == sfb_pkg::CMD_DRAW))
    else $error("collision raised by a command other than draw");

  // After a collision only the drawn row is left in the store.
  assert property (@(posedge clk) disable iff (rst)
    (ram_we && span_hit) |=> ($countones(valid) == 1))
    else $error("store not emptied on collision");

endmodule

`default_nettype wire

[src/sfb_ram.sv]
// Generic single-port-write RAM with one registered read port.
`default_nettype none

module sfb_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 32
) (
  input  wire logic                       clk,
  input  wire logic                       we,
  input  wire logic [$clog2(DEPTH)-1:0]   waddr,
  input  wire logic [WIDTH-1:0]           wdata,
  input  wire logic [$clog2(DEPTH)-1:0]   raddr,
  output logic      [WIDTH-1:0]           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[src/sfb_span_unit.sv]
// Span unit: builds the shifted pixel mask of a span and merges it into a row.
`default_nettype none

module sfb_span_unit #(
  parameter int COLUMNS          = 128,
  parameter int MAX_SPRITE_WIDTH = 16
) (
  input  wire sfb_pkg::span_req_t   req,
  input  wire logic [COLUMNS-1:0]   old_row,
  input  wire logic                 check_en,
  output logic      [COLUMNS-1:0]   new_row,
  output logic                      hit
);

  localparam int LIMIT = (MAX_SPRITE_WIDTH < sfb_pkg::SPRITE_BITS) ?
                         MAX_SPRITE_WIDTH : sfb_pkg::SPRITE_BITS;

  logic [4:0]                          n;
  logic [sfb_pkg::SPRITE_BITS-1:0]     base;
  logic [COLUMNS+sfb_pkg::SPRITE_BITS-1:0] wide;
  logic [COLUMNS-1:0]                  mask;

  // Saturate the span length and form the unshifted pixel pattern.
  always_comb begin
    if (int'(req.span) > LIMIT) begin
      n = 5'(LIMIT);
    end else begin
      n = req.span;
    end
    for (int j = 0; j < sfb_pkg::SPRITE_BITS; j++) begin
      base[j] = (5'(j) < n) && (req.clear || req.bits[j]);
    end
  end

  // Shift to the start column; columns past the right edge fall off.
  assign wide = {{COLUMNS{1'b0}}, base} << req.col;
  assign mask = wide[COLUMNS-1:0];

  // A draw that lands on a lit pixel above ground collides.
  assign hit = check_en && !req.clear && (|(mask & old_row));

  // Merge: clear span, draw over a cleared store, or plain draw.
  always_comb begin
    if (req.clear) begin
      new_row = old_row & ~mask;
    end else if (hit) begin
      new_row = mask;
    end else begin
      new_row = old_row | mask;
    end
  end

endmodule

`default_nettype wire
